// ===== src/ats_pkg.sv =====
// Shared types and constants for the adaptive threshold step counter.
// Item, result, job and register-file structs, register indexes and reset values.
// No dependencies; every other file of the block imports this package.
package ats_pkg;

    localparam int ACCEL_W    = 16;
    localparam int ELAPSED_W  = 16;
    localparam int SUMSQ_W    = 32;
    localparam int MAG_W      = 16;
    localparam int ENV_W      = 17;
    localparam int WIN_W      = 8;
    localparam int TOTAL_W    = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int SQRT_STEPS = SUMSQ_W / 2;
    localparam int JOB_QUEUE_DEPTH = 2;

    // Operation codes of an input item.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_AMPLITUDE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL_MS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP_COUNT    = 3'd4;

    // Register reset values.
    localparam logic [ENV_W-1:0]     RST_INITIAL_THRESHOLD = 17'd18000;
    localparam logic [WIN_W-1:0]     RST_WINDOW_LENGTH     = 8'd50;
    localparam logic [15:0]          RST_MIN_AMPLITUDE     = 16'd2000;
    localparam logic [15:0]          RST_MIN_INTERVAL_MS   = 16'd250;
    localparam logic [TOTAL_W-1:0]   RST_MAX_STEP_COUNT    = 24'hFF_FFFF;

    // An empty envelope minimum, and a threshold that no magnitude reaches.
    localparam logic [ENV_W-1:0] ENV_EMPTY = 17'h1_FFFF;
    localparam logic [ENV_W-1:0] THR_OFF   = 17'h1_FFFF;

    // Largest floor square root of three squared 16-bit samples.
    localparam logic [MAG_W-1:0] MAG_MAX = 16'd56755;

    typedef struct packed {
        logic                        operation;
        logic signed [ACCEL_W-1:0]   accel_x;
        logic signed [ACCEL_W-1:0]   accel_y;
        logic signed [ACCEL_W-1:0]   accel_z;
        logic [ELAPSED_W-1:0]        delta_ms;
    } t_in_item;

    typedef struct packed {
        logic [TOTAL_W-1:0] step_total;
        logic               step_counted;
        logic [MAG_W-1:0]   magnitude;
        logic               window_closed;
    } t_out_item;

    // What the front end hands to the back end for one item.
    typedef struct packed {
        logic                 operation;
        logic [SUMSQ_W-1:0]   sum_sq;
        logic [ELAPSED_W-1:0] delta_ms;
    } t_job;

    typedef struct packed {
        logic [ENV_W-1:0]   initial_threshold;
        logic [WIN_W-1:0]   window_length;
        logic [15:0]        min_amplitude;
        logic [15:0]        min_interval_ms;
        logic [TOTAL_W-1:0] max_step_count;
    } t_cfg;

endpackage

// ===== src/ats_front.sv =====
// Front end: accepts input items and forms the sum of squares of the three axes.
// One shared 16x16 multiplier squares one axis per cycle. Depends on ats_pkg.
module ats_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_full,
    input  ats_pkg::t_in_item i_item,
    output logic            o_job_valid,
    input  logic            i_job_full,
    output ats_pkg::t_job   o_job
);
    import ats_pkg::*;

    typedef enum logic [2:0] {
        F_IDLE   = 3'b001,
        F_SQUARE = 3'b010,
        F_PUSH   = 3'b100
    } t_front_state;

    t_front_state r_state, n_state;
    logic [1:0]   r_idx, n_idx;
    logic [SUMSQ_W-1:0] r_prod, n_prod;
    logic [SUMSQ_W-1:0] r_acc, n_acc;
    logic               r_op;
    logic [ELAPSED_W-1:0] r_elapsed;
    logic signed [ACCEL_W-1:0] r_x, r_y, r_z;

    logic signed [ACCEL_W-1:0]   w_opnd;
    logic signed [SUMSQ_W-1:0]   w_sq;
    logic                        w_accept;

    assign o_full   = (r_state != F_IDLE);
    assign w_accept = i_push && !o_full;

    always_comb begin
        unique case (r_idx)
            2'd0:    w_opnd = r_x;
            2'd1:    w_opnd = r_y;
            2'd2:    w_opnd = r_z;
            default: w_opnd = '0;
        endcase
    end

    assign w_sq = w_opnd * w_opnd;

    // The accumulator adds the registered product of the previous pass, so the fourth
    // pass only adds the last square.
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_prod  = r_prod;
        n_acc   = r_acc;
        unique case (r_state)
            F_IDLE: begin
                if (w_accept) begin
                    n_idx   = '0;
                    n_prod  = '0;
                    n_acc   = '0;
                    n_state = (i_item.operation == OP_CLEAR) ? F_PUSH : F_SQUARE;
                end
            end
            F_SQUARE: begin
                n_acc  = r_acc + r_prod;
                n_prod = SUMSQ_W'(unsigned'(w_sq));
                n_idx  = r_idx + 2'd1;
                if (r_idx == 2'd3) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_job_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_prod <= n_prod;
        r_acc  <= n_acc;
        if (w_accept) begin
            r_op      <= i_item.operation;
            r_elapsed <= i_item.delta_ms;
            r_x       <= i_item.accel_x;
            r_y       <= i_item.accel_y;
            r_z       <= i_item.accel_z;
        end
    end

    assign o_job_valid    = (r_state == F_PUSH);
    assign o_job.operation = r_op;
    assign o_job.sum_sq   = r_acc;
    assign o_job.delta_ms = r_elapsed;

endmodule

// ===== src/ats_queue.sv =====
// Short job queue between the front end and the back end.
// Register-based ring of t_job entries with a fill count. Depends on ats_pkg.
module ats_queue #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ats_pkg::t_job i_item,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output ats_pkg::t_job o_item
);
    import ats_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_do_push, w_do_pop;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_item    = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (w_do_push) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        unique case ({w_do_push, w_do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

// ===== src/ats_sqrt.sv =====
// Iterative floor square root of a 32-bit value, two radicand bits per cycle.
// Restoring digit-by-digit method; result after sixteen steps. Depends on ats_pkg.
module ats_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ats_pkg::SUMSQ_W-1:0] i_value,
    output logic                        o_done,
    output logic [ats_pkg::MAG_W-1:0]   o_root
);
    import ats_pkg::*;

    localparam int STEP_W = $clog2(SQRT_STEPS);
    localparam int REM_W  = MAG_W + 1;

    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [SUMSQ_W-1:0]  r_val, n_val;
    logic [REM_W-1:0]    r_rem, n_rem;
    logic [MAG_W-1:0]    r_root, n_root;

    logic [REM_W+1:0]    w_rem_t;
    logic [REM_W+1:0]    w_trial;
    logic                w_ge;

    // Bring down the next two radicand bits and try the next root bit.
    assign w_rem_t = {r_rem, r_val[SUMSQ_W-1 -: 2]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_ge    = (w_rem_t >= w_trial);

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_val  = r_val;
        n_rem  = r_rem;
        n_root = r_root;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_val  = i_value;
            n_rem  = '0;
            n_root = '0;
        end else if (r_busy) begin
            n_val  = r_val << 2;
            n_rem  = w_ge ? REM_W'(w_rem_t - w_trial) : w_rem_t[REM_W-1:0];
            n_root = {r_root[MAG_W-2:0], w_ge};
            n_step = r_step + 1'b1;
            if (r_step == STEP_W'(SQRT_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step <= n_step;
        r_val  <= n_val;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ===== src/ats_back.sv =====
// Back end: square root, envelope and threshold tracking, step decision, result register.
// Takes jobs from the queue one at a time. Depends on ats_pkg and ats_sqrt.
module ats_back #(
    parameter int COUNT_WIDTH = 24,
    parameter int TIME_WIDTH  = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ats_pkg::t_cfg      i_cfg,
    input  logic               i_job_empty,
    input  ats_pkg::t_job      i_job,
    output logic               o_job_pop,
    output logic               o_res_valid,
    input  logic               i_res_pop,
    output ats_pkg::t_out_item o_result
);
    import ats_pkg::*;

    localparam int LIM_W = (COUNT_WIDTH > TOTAL_W) ? COUNT_WIDTH : TOTAL_W;

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_ROOT = 4'b0010,
        B_ENV  = 4'b0100,
        B_STEP = 4'b1000
    } t_back_state;

    t_back_state          r_state, n_state;
    logic [TIME_WIDTH-1:0] r_run, n_run;
    logic [TIME_WIDTH-1:0] r_last, n_last;
    logic                  r_above, n_above;
    logic [ENV_W-1:0]      r_env_min, n_env_min;
    logic [MAG_W-1:0]      r_env_max, n_env_max;
    logic [ENV_W-1:0]      r_thr, n_thr;
    logic [WIN_W-1:0]      r_wc, n_wc;
    logic [COUNT_WIDTH-1:0] r_cnt, n_cnt;
    logic                  r_res_valid, n_res_valid;

    logic                  r_op;
    logic [ELAPSED_W-1:0]  r_elapsed;
    logic [MAG_W-1:0]      r_mag, n_mag;
    logic                  r_closed, n_closed;
    t_out_item             r_result, n_result;

    logic                  w_sqrt_start;
    logic                  w_sqrt_done;
    logic [MAG_W-1:0]      w_root;

    logic [MAG_W-1:0]      w_max_upd;
    logic [ENV_W-1:0]      w_min_upd;
    logic [WIN_W-1:0]      w_wc_inc;
    logic                  w_close;
    logic [ENV_W-1:0]      w_amp;
    logic [ENV_W-1:0]      w_mid;

    logic                  w_cross;
    logic [TIME_WIDTH-1:0] w_dt;
    logic                  w_dt_ok;
    logic [LIM_W-1:0]      w_limit;
    logic [LIM_W-1:0]      w_max_ext;
    logic [LIM_W-1:0]      w_mask_ext;
    logic                  w_can_inc;
    logic                  w_slot_free;
    logic [LIM_W-1:0]      w_total_ext;
    logic                  w_counted;

    assign o_job_pop    = (r_state == B_IDLE) && !i_job_empty;
    assign w_sqrt_start = o_job_pop && (i_job.operation == OP_SAMPLE);
    assign w_slot_free  = !r_res_valid || i_res_pop;

    ats_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sqrt_start),
        .i_value (i_job.sum_sq),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    // Envelope fold and window close.
    assign w_max_upd = (r_mag > r_env_max) ? r_mag : r_env_max;
    assign w_min_upd = ({1'b0, r_mag} < r_env_min) ? {1'b0, r_mag} : r_env_min;
    assign w_wc_inc  = r_wc + 1'b1;
    assign w_close   = (w_wc_inc >= i_cfg.window_length);
    assign w_amp     = ({1'b0, w_max_upd} > w_min_upd)
                     ? ENV_W'({1'b0, w_max_upd} - w_min_upd) : '0;
    assign w_mid     = ENV_W'(((ENV_W + 1)'(w_min_upd) + (ENV_W + 1)'(w_max_upd)) >> 1);

    // Step decision against the threshold left by the envelope pass.
    assign w_cross    = ({1'b0, r_mag} >= r_thr);
    assign w_dt       = r_run - r_last;
    assign w_dt_ok    = (w_dt >= TIME_WIDTH'(i_cfg.min_interval_ms));
    assign w_max_ext  = LIM_W'(i_cfg.max_step_count);
    assign w_mask_ext = LIM_W'({COUNT_WIDTH{1'b1}});
    assign w_limit    = (w_max_ext > w_mask_ext) ? w_mask_ext : w_max_ext;
    assign w_can_inc  = (LIM_W'(r_cnt) < w_limit);

    always_comb begin
        n_state     = r_state;
        n_run       = r_run;
        n_last      = r_last;
        n_above     = r_above;
        n_env_min   = r_env_min;
        n_env_max   = r_env_max;
        n_thr       = r_thr;
        n_wc        = r_wc;
        n_cnt       = r_cnt;
        n_res_valid = r_res_valid;
        n_mag       = r_mag;
        n_closed    = r_closed;
        n_result    = r_result;
        w_counted   = 1'b0;
        w_total_ext = '0;

        if (i_res_pop) begin
            n_res_valid = 1'b0;
        end

        unique case (r_state)
            B_IDLE: begin
                if (o_job_pop) begin
                    n_mag   = '0;
                    n_state = (i_job.operation == OP_CLEAR) ? B_ENV : B_ROOT;
                end
            end
            B_ROOT: begin
                if (w_sqrt_done) begin
                    n_mag   = w_root;
                    n_state = B_ENV;
                end
            end
            B_ENV: begin
                n_state = B_STEP;
                if (r_op == OP_CLEAR) begin
                    n_cnt     = '0;
                    n_last    = r_run;
                    n_above   = 1'b0;
                    n_env_min = ENV_EMPTY;
                    n_env_max = '0;
                    n_wc      = '0;
                    n_thr     = i_cfg.initial_threshold;
                    n_closed  = 1'b0;
                end else begin
                    n_run = r_run + TIME_WIDTH'(r_elapsed);
                    if (w_close) begin
                        n_thr     = (w_amp >= ENV_W'(i_cfg.min_amplitude)) ? w_mid : THR_OFF;
                        n_env_min = ENV_EMPTY;
                        n_env_max = '0;
                        n_wc      = '0;
                        n_closed  = 1'b1;
                    end else begin
                        n_env_min = w_min_upd;
                        n_env_max = w_max_upd;
                        n_wc      = w_wc_inc;
                        n_closed  = 1'b0;
                    end
                end
            end
            B_STEP: begin
                if (w_slot_free) begin
                    if (r_op == OP_SAMPLE) begin
                        if (w_cross) begin
                            if (!r_above) begin
                                if (w_dt_ok) begin
                                    if (w_can_inc) begin
                                        n_cnt     = r_cnt + 1'b1;
                                        w_counted = 1'b1;
                                    end
                                    n_last = r_run;
                                end
                                n_above = 1'b1;
                            end
                        end else begin
                            n_above = 1'b0;
                        end
                    end
                    w_total_ext            = LIM_W'(n_cnt);
                    n_result.step_total    = w_total_ext[TOTAL_W-1:0];
                    n_result.step_counted  = w_counted;
                    n_result.magnitude     = r_mag;
                    n_result.window_closed = r_closed;
                    n_res_valid            = 1'b1;
                    n_state                = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_run       <= '0;
            r_last      <= '0;
            r_above     <= 1'b0;
            r_env_min   <= ENV_EMPTY;
            r_env_max   <= '0;
            r_thr       <= RST_INITIAL_THRESHOLD;
            r_wc        <= '0;
            r_cnt       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_run       <= n_run;
            r_last      <= n_last;
            r_above     <= n_above;
            r_env_min   <= n_env_min;
            r_env_max   <= n_env_max;
            r_thr       <= n_thr;
            r_wc        <= n_wc;
            r_cnt       <= n_cnt;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_op      <= i_job.operation;
            r_elapsed <= i_job.delta_ms;
        end
        r_mag    <= n_mag;
        r_closed <= n_closed;
        r_result <= n_result;
    end

    assign o_res_valid = r_res_valid;
    assign o_result    = r_result;

endmodule

// ===== src/adaptive_threshold_step_counter.sv =====
// Top level of the adaptive threshold step counter: register file, front end,
// job queue and back end. Depends on ats_pkg, ats_front, ats_queue and ats_back.
//
//   Channel   Direction  Handshake                 Payload
//   input     in         push / full               i_item   (t_in_item)
//   result    out        empty / pop               o_result (t_out_item)
//   config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A sample holds the back end while it takes the job, runs the square root (sixteen
// two-bit steps and its done flag), then passes the envelope and step decision states;
// this loop sets the rate while the front end squares ahead.
// A clear skips the squaring and the square root.
// Synchronous reset clears control and configuration state; the block is ready the cycle after.
// A result that is not popped stalls the back end, then the queue, then full.
module adaptive_threshold_step_counter #(
    parameter int COUNT_WIDTH = 24,
    parameter int TIME_WIDTH  = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  ats_pkg::t_in_item              i_item,
    output logic                           empty,
    input  logic                           pop,
    output ats_pkg::t_out_item             o_result,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ats_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ats_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ats_pkg::*;

    t_cfg  r_cfg, n_cfg;
    t_job  w_front_job, w_queue_job;
    logic  w_front_valid;
    logic  w_queue_full, w_queue_empty;
    logic  w_job_pop;
    logic  w_res_valid;
    logic  w_res_pop;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_INITIAL_THRESHOLD: n_cfg.initial_threshold = i_cfg_data[ENV_W-1:0];
                CFG_WINDOW_LENGTH:     n_cfg.window_length     = i_cfg_data[WIN_W-1:0];
                CFG_MIN_AMPLITUDE:     n_cfg.min_amplitude     = i_cfg_data[15:0];
                CFG_MIN_INTERVAL_MS:   n_cfg.min_interval_ms   = i_cfg_data[15:0];
                CFG_MAX_STEP_COUNT:    n_cfg.max_step_count    = i_cfg_data[TOTAL_W-1:0];
                default:               n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.initial_threshold <= RST_INITIAL_THRESHOLD;
            r_cfg.window_length     <= RST_WINDOW_LENGTH;
            r_cfg.min_amplitude     <= RST_MIN_AMPLITUDE;
            r_cfg.min_interval_ms   <= RST_MIN_INTERVAL_MS;
            r_cfg.max_step_count    <= RST_MAX_STEP_COUNT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    ats_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_item      (i_item),
        .o_job_valid (w_front_valid),
        .i_job_full  (w_queue_full),
        .o_job       (w_front_job)
    );

    ats_queue #(
        .DEPTH (JOB_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_valid),
        .i_item  (w_front_job),
        .o_full  (w_queue_full),
        .i_pop   (w_job_pop),
        .o_empty (w_queue_empty),
        .o_item  (w_queue_job)
    );

    ats_back #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .TIME_WIDTH  (TIME_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_empty (w_queue_empty),
        .i_job       (w_queue_job),
        .o_job_pop   (w_job_pop),
        .o_res_valid (w_res_valid),
        .i_res_pop   (w_res_pop),
        .o_result    (o_result)
    );

    assign empty     = !w_res_valid;
    assign w_res_pop = pop && w_res_valid;

endmodule

// ===== src/ats_checker.sv =====
// Port-level checks for the adaptive threshold step counter, bound to the top level.
// Depends on ats_pkg and adaptive_threshold_step_counter.
module ats_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input ats_pkg::t_out_item o_result
);
    import ats_pkg::*;

    // Reset leaves no result waiting and the input side open.
    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("block not idle after reset");

    // A waiting result that is not taken stays and does not change.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("waiting result changed or vanished");

    // No magnitude exceeds the root of three full-scale squares.
    a_mag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.magnitude <= MAG_MAX))
        else $error("magnitude out of range");

    // A counted step leaves a nonzero total behind it.
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.step_counted) |-> (o_result.step_total != '0))
        else $error("step counted with zero total");

endmodule

bind adaptive_threshold_step_counter ats_checker u_ats_checker (.*);
